// ===== sv/ezr_pkg.sv =====
//==============================================================================
// ezr_pkg
// Shared constants, types and tables for the Euler ZYX to rotation matrix unit.
//==============================================================================
package ezr_pkg;

    localparam int ANGLE_W     = 16;
    localparam int OUT_W       = 16;
    localparam int AFRAC       = 13;
    localparam int OFRAC       = 14;
    localparam int QF          = 30;
    localparam int ITERS       = 30;
    // Bits of a CORDIC step index
    localparam int STEP_W      = 5;
    // Q30 working values stay well inside 36 bits
    localparam int QW          = 36;

    localparam logic signed [QW-1:0] PI_Q      = 36'sd3373259426;
    localparam logic signed [QW-1:0] HALF_PI_Q = 36'sd1686629713;
    localparam logic signed [QW-1:0] TWO_PI_Q  = 36'sd6746518852;
    localparam logic signed [QW-1:0] GAIN_INV  = 36'sd652032874;

    typedef logic signed [QW-1:0] q_t;

    // One angle in flight through the CORDIC row
    typedef struct packed {
        q_t   x;
        q_t   y;
        q_t   z;
        logic neg;
    } rot_t;

    // One word of all three angles
    typedef struct packed {
        rot_t yaw;
        rot_t pitch;
        rot_t roll;
    } rot3_t;

    function automatic q_t atan_q(input int i);
        q_t r;
        r = '0;
        case (i)
            0: r = 36'sd843314856;   1: r = 36'sd497837829;
            2: r = 36'sd263043836;   3: r = 36'sd133525158;
            4: r = 36'sd67021686;    5: r = 36'sd33543515;
            6: r = 36'sd16775850;    7: r = 36'sd8388437;
            8: r = 36'sd4194282;     9: r = 36'sd2097149;
            10: r = 36'sd1048575;    11: r = 36'sd524287;
            12: r = 36'sd262143;     13: r = 36'sd131071;
            14: r = 36'sd65535;      15: r = 36'sd32767;
            16: r = 36'sd16383;      17: r = 36'sd8191;
            18: r = 36'sd4095;       19: r = 36'sd2047;
            20: r = 36'sd1023;       21: r = 36'sd511;
            22: r = 36'sd255;        23: r = 36'sd127;
            24: r = 36'sd63;         25: r = 36'sd31;
            26: r = 36'sd15;         27: r = 36'sd7;
            28: r = 36'sd3;          29: r = 36'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round a Q60 product back to Q30
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [2*QW-1:0] p;
        p = a * b + (72'sd1 <<< (QF - 1));
        return q_t'(p >>> QF);
    endfunction

    // Round Q30 to the output format and clamp
    function automatic logic signed [OUT_W-1:0] to_out(input q_t v);
        q_t r;
        q_t lim;
        lim = q_t'(1) <<< OFRAC;
        r = (v + (q_t'(1) <<< (QF - OFRAC - 1))) >>> (QF - OFRAC);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/ezr_reduce.sv =====
//==============================================================================
// ezr_reduce
// Scale one angle to Q30, reduce into (-pi, pi] and fold into [-pi/2, pi/2].
//==============================================================================
module ezr_reduce
    import ezr_pkg::*;
(
    input  logic signed [ANGLE_W-1:0] angle,
    output rot_t                      rot
);

    q_t z0;
    q_t z1;
    q_t z2;

    // Input spans about +-4 radians, so one step each way covers the modulo
    always_comb
    begin
        z0 = q_t'(angle) <<< (QF - AFRAC);
        z1 = z0;
        if (z1 > PI_Q)
            z1 = z1 - TWO_PI_Q;
        else if (z1 <= -PI_Q)
            z1 = z1 + TWO_PI_Q;
        z2 = z1;
        rot.neg = 1'b0;
        if (z1 > HALF_PI_Q)
        begin
            z2 = z1 - PI_Q;
            rot.neg = 1'b1;
        end
        else if (z1 < -HALF_PI_Q)
        begin
            z2 = z1 + PI_Q;
            rot.neg = 1'b1;
        end
        rot.x = GAIN_INV;
        rot.y = '0;
        rot.z = z2;
    end

endmodule

// ===== sv/ezr_cell.sv =====
//==============================================================================
// ezr_cell
// One CORDIC micro-rotation for all three angles, registered.
//==============================================================================
module ezr_cell
    import ezr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [STEP_W-1:0] step,
    input  logic              valid_in,
    input  rot3_t             data_in,
    output logic              valid_out,
    output rot3_t             data_out
);

    logic  valid_reg;
    rot3_t data_reg;
    rot3_t data_next;

    // step is tied to a constant at each place in the row
    function automatic rot_t rotate(input rot_t r, input logic [STEP_W-1:0] sh);
        rot_t o;
        o = r;
        if (r.z >= 0)
        begin
            o.x = r.x - (r.y >>> sh);
            o.y = r.y + (r.x >>> sh);
            o.z = r.z - atan_q(int'(sh));
        end
        else
        begin
            o.x = r.x + (r.y >>> sh);
            o.y = r.y - (r.x >>> sh);
            o.z = r.z + atan_q(int'(sh));
        end
        return o;
    endfunction

    // Rotate each angle by this step's arctangent
    always_comb
    begin
        data_next.yaw   = rotate(data_in.yaw, step);
        data_next.pitch = rotate(data_in.pitch, step);
        data_next.roll  = rotate(data_in.roll, step);
    end

    // Advance when the row moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== sv/ezr_matrix.sv =====
//==============================================================================
// ezr_matrix
// Form the nine matrix entries from sines and cosines over three stages.
//==============================================================================
module ezr_matrix
    import ezr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_in,
    input  rot3_t data_in,
    output logic  valid_out,
    output logic signed [OUT_W-1:0] m00,
    output logic signed [OUT_W-1:0] m01,
    output logic signed [OUT_W-1:0] m02,
    output logic signed [OUT_W-1:0] m10,
    output logic signed [OUT_W-1:0] m11,
    output logic signed [OUT_W-1:0] m12,
    output logic signed [OUT_W-1:0] m20,
    output logic signed [OUT_W-1:0] m21,
    output logic signed [OUT_W-1:0] m22
);

    logic [2:0] valid_reg;
    // Stage 1: apply folds
    q_t sz_reg, cz_reg, sy_reg, cy_reg, sx_reg, cx_reg;
    // Stage 2: first products
    q_t sxsy_reg, cxsy_reg, cycz_reg, cxsz_reg, sxsz_reg, cysz_reg, cxcz_reg, sxcz_reg;
    q_t sxcy_reg, cxcy_reg, nsy_reg, sz2_reg, cz2_reg;
    // Stage 3: second products and sums
    logic signed [OUT_W-1:0] o_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], valid_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sz_reg <= data_in.yaw.neg   ? -data_in.yaw.y   : data_in.yaw.y;
            cz_reg <= data_in.yaw.neg   ? -data_in.yaw.x   : data_in.yaw.x;
            sy_reg <= data_in.pitch.neg ? -data_in.pitch.y : data_in.pitch.y;
            cy_reg <= data_in.pitch.neg ? -data_in.pitch.x : data_in.pitch.x;
            sx_reg <= data_in.roll.neg  ? -data_in.roll.y  : data_in.roll.y;
            cx_reg <= data_in.roll.neg  ? -data_in.roll.x  : data_in.roll.x;

            sxsy_reg <= qmul(sx_reg, sy_reg);
            cxsy_reg <= qmul(cx_reg, sy_reg);
            cycz_reg <= qmul(cy_reg, cz_reg);
            cxsz_reg <= qmul(cx_reg, sz_reg);
            sxsz_reg <= qmul(sx_reg, sz_reg);
            cysz_reg <= qmul(cy_reg, sz_reg);
            cxcz_reg <= qmul(cx_reg, cz_reg);
            sxcz_reg <= qmul(sx_reg, cz_reg);
            sxcy_reg <= qmul(sx_reg, cy_reg);
            cxcy_reg <= qmul(cx_reg, cy_reg);
            nsy_reg  <= -sy_reg;
            sz2_reg  <= sz_reg;
            cz2_reg  <= cz_reg;

            o_reg[0] <= to_out(cycz_reg);
            o_reg[1] <= to_out(qmul(sxsy_reg, cz2_reg) - cxsz_reg);
            o_reg[2] <= to_out(qmul(cxsy_reg, cz2_reg) + sxsz_reg);
            o_reg[3] <= to_out(cysz_reg);
            o_reg[4] <= to_out(qmul(sxsy_reg, sz2_reg) + cxcz_reg);
            o_reg[5] <= to_out(qmul(cxsy_reg, sz2_reg) - sxcz_reg);
            o_reg[6] <= to_out(nsy_reg);
            o_reg[7] <= to_out(sxcy_reg);
            o_reg[8] <= to_out(cxcy_reg);
        end
    end

    assign valid_out = valid_reg[2];
    assign m00 = o_reg[0];
    assign m01 = o_reg[1];
    assign m02 = o_reg[2];
    assign m10 = o_reg[3];
    assign m11 = o_reg[4];
    assign m12 = o_reg[5];
    assign m20 = o_reg[6];
    assign m21 = o_reg[7];
    assign m22 = o_reg[8];

endmodule

// ===== sv/euler_zyx_to_rotation_matrix_unit.sv =====
//==============================================================================
// euler_zyx_to_rotation_matrix_unit
// Yaw, pitch, roll angles to the 3x3 rotation matrix Rz*Ry*Rx in Q1.14.
//==============================================================================
// channel | signals                             | direction
// in      | in_valid, in_stall, *_angle         | word in
// out     | out_valid, out_stall, m00 .. m22    | word out
//
// Words pass through the CORDIC row and then the matrix stages; one word is
// accepted per cycle unless stalled. The whole pipeline advances together
// and holds on a stall while the output word is waiting; in_stall then mirrors
// out_stall when the output register is full. Reset clears only the valid bits.
//==============================================================================
module euler_zyx_to_rotation_matrix_unit
    import ezr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [ANGLE_W-1:0] yaw_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [OUT_W-1:0]   m00,
    output logic signed [OUT_W-1:0]   m01,
    output logic signed [OUT_W-1:0]   m02,
    output logic signed [OUT_W-1:0]   m10,
    output logic signed [OUT_W-1:0]   m11,
    output logic signed [OUT_W-1:0]   m12,
    output logic signed [OUT_W-1:0]   m20,
    output logic signed [OUT_W-1:0]   m21,
    output logic signed [OUT_W-1:0]   m22
);

    logic  en;
    rot3_t head;
    rot3_t chain [ITERS+1];
    logic  vchain [ITERS+1];

    // Advance whenever the output word is empty or being taken
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    ezr_reduce u_red_yaw   (.angle(yaw_angle),   .rot(head.yaw));
    ezr_reduce u_red_pitch (.angle(pitch_angle), .rot(head.pitch));
    ezr_reduce u_red_roll  (.angle(roll_angle),  .rot(head.roll));

    assign chain[0]  = head;
    assign vchain[0] = in_valid;

    // Row of CORDIC cells, one micro-rotation each
    for (genvar i = 0; i < ITERS; i++)
    begin : g_cell
        ezr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (STEP_W'(i)),
            .valid_in  (vchain[i]),
            .data_in   (chain[i]),
            .valid_out (vchain[i+1]),
            .data_out  (chain[i+1])
        );
    end

    ezr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (vchain[ITERS]),
        .data_in   (chain[ITERS]),
        .valid_out (out_valid),
        .m00 (m00), .m01 (m01), .m02 (m02),
        .m10 (m10), .m11 (m11), .m12 (m12),
        .m20 (m20), .m21 (m21), .m22 (m22)
    );

endmodule
